// ===== src/triangle_fence_point_counter_core_defines.svh =====
// ----------------------------------------------------------------------------
// Triangle fence point counter assertion macros
// Shared concurrent assertion wrappers, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_FENCE_POINT_COUNTER_CORE_DEFINES_SVH
`define TRIANGLE_FENCE_POINT_COUNTER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define TFPC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define TFPC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define TFPC_ASSERT_NOW(lbl, ante, cons, msg)
`define TFPC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== src/tfpc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle fence point counter package
// Types, register codes and cross product helpers shared by the block.
// ----------------------------------------------------------------------------
package tfpc_pkg;

	localparam int CNT_W = 20;
	localparam logic [CNT_W-1:0] CNT_CAP = 20'hFFFFF;
	localparam int CFG_IDX_W = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FENCE_ZERO = 2'd0,
		REG_FENCE_ONE  = 2'd1,
		REG_FENCE_TWO  = 2'd2
	} cfg_reg_t;

	typedef logic signed [15:0] coord_t;

	typedef struct packed {
		coord_t by;
		coord_t bx;
		coord_t ay;
		coord_t ax;
	} seg_t;

	typedef struct packed {
		logic signed [33:0] lhs;
		logic signed [33:0] rhs;
	} prod_pair_t;

	typedef struct packed {
		logic neg;
		logic zero;
	} sgn_t;

	typedef struct packed {
		logic       closed;
		logic [2:0] flip;
	} fence_stat_t;

	function automatic prod_pair_t cross_prods(seg_t s, coord_t cx, coord_t cy);
		logic signed [16:0] dx;
		logic signed [16:0] dy;
		logic signed [16:0] ex;
		logic signed [16:0] ey;
		prod_pair_t p;
		dx = 17'(s.bx) - 17'(s.ax);
		dy = 17'(s.by) - 17'(s.ay);
		ex = 17'(cx) - 17'(s.ax);
		ey = 17'(cy) - 17'(s.ay);
		p.lhs = 34'(dx) * 34'(ey);
		p.rhs = 34'(dy) * 34'(ex);
		return p;
	endfunction

	function automatic sgn_t cross_sign(prod_pair_t p);
		logic signed [34:0] d;
		sgn_t s;
		d = 35'(p.lhs) - 35'(p.rhs);
		s.neg  = d[34];
		s.zero = (d == '0);
		return s;
	endfunction

endpackage

// ===== src/tfpc_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle fence point counter channels
// Point, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface tfpc_pt_if import tfpc_pkg::*;;
	logic   valid;
	logic   ready;
	coord_t tree_x;
	coord_t tree_y;
	logic   last_tree;

	modport source(output valid, tree_x, tree_y, last_tree, input ready);
	modport sink(input valid, tree_x, tree_y, last_tree, output ready);
endinterface

interface tfpc_res_if import tfpc_pkg::*;;
	logic             valid;
	logic             ready;
	logic             tree_inside;
	logic [CNT_W-1:0] outside_so_far;
	logic             fences_closed;
	logic             batch_end;

	modport source(output valid, tree_inside, outside_so_far, fences_closed, batch_end,
		input ready);
	modport sink(input valid, tree_inside, outside_so_far, fences_closed, batch_end,
		output ready);
endinterface

interface tfpc_cfg_if import tfpc_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [63:0]          data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ===== src/triangle_fence_point_counter_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle fence point counter core
// Classifies points against a triangle built from three configured fences.
// ----------------------------------------------------------------------------
// The cfg channel writes one 64-bit fence per word (index 0 to 2), is always
// ready, and leaves it to the user to write it only while no point is in flight.
// The pts channel takes one point per word and the res channel returns one
// word per point, in order: inside flag, saturating count of outside points
// in the current batch, closure flag and batch end marker.
// A point word is accepted every cycle while res does not stall; its result
// word is registered first in the input register and then in the result
// register, with the cross products, sign tests and count update between them.
// Closure and orientation are derived combinationally from the fences, so a
// point accepted right after a fence write already sees the new fences.
// When res stalls, the input register fills and then pts.ready drops until
// the result word is taken; pts.ready follows res.ready in the same cycle.
// Reset clears the fences, the batch count and both stage valid bits.
// ----------------------------------------------------------------------------
`include "triangle_fence_point_counter_core_defines.svh"

module triangle_fence_point_counter_core import tfpc_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	tfpc_cfg_if.sink     cfg,
	tfpc_pt_if.sink      pts,
	tfpc_res_if.source   res
);

	seg_t             fence_q [3];
	fence_stat_t      stat;

	logic             en1;
	logic             en2;

	logic             v_s1;
	coord_t           x_s1;
	coord_t           y_s1;
	logic             last_s1;

	logic             v_s2;
	logic             inside_s2;
	logic [CNT_W-1:0] count_s2;
	logic             closed_s2;
	logic             last_s2;

	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] cnt_nx;
	logic [2:0]       left_v;
	logic             in_tri;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fence_q[0] <= '0;
			fence_q[1] <= '0;
			fence_q[2] <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_FENCE_ZERO: fence_q[0] <= cfg.data;
				REG_FENCE_ONE:  fence_q[1] <= cfg.data;
				REG_FENCE_TWO:  fence_q[2] <= cfg.data;
				default: ;
			endcase
		end
	end

	tfpc_fence u_fence (
		.fence  (fence_q),
		.stat   (stat)
	);

	assign en2 = !v_s2 || res.ready;
	assign en1 = !v_s1 || en2;
	assign pts.ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= pts.valid;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && pts.valid) begin
			x_s1    <= pts.tree_x;
			y_s1    <= pts.tree_y;
			last_s1 <= pts.last_tree;
		end
	end

	// A flipped fence negates the cross product, so left turns become positive.
	for (genvar gi = 0; gi < 3; gi++) begin : g_side
		sgn_t s;
		assign s = cross_sign(cross_prods(fence_q[gi], x_s1, y_s1));
		assign left_v[gi] = stat.flip[2 - gi] ? (!s.neg && !s.zero) : s.neg;
	end

	assign in_tri = stat.closed && ((&left_v) || !(|left_v));
	assign cnt_nx = (in_tri || cnt_q == CNT_CAP) ? cnt_q : cnt_q + 20'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (en2 && v_s1) begin
			cnt_q <= last_s1 ? '0 : cnt_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (en2 && v_s1) begin
			inside_s2 <= in_tri;
			count_s2  <= cnt_nx;
			closed_s2 <= stat.closed;
			last_s2   <= last_s1;
		end
	end

	assign res.valid          = v_s2;
	assign res.tree_inside    = inside_s2;
	assign res.outside_so_far = count_s2;
	assign res.fences_closed  = closed_s2;
	assign res.batch_end      = last_s2;

	`TFPC_ASSERT_NOW(a_open_never_inside, res.valid && !res.fences_closed, !res.tree_inside, "open fence reported an inside point")
	`TFPC_ASSERT_NOW(a_outside_counted, res.valid && !res.tree_inside, res.outside_so_far != '0, "outside point left the count at zero")
	`TFPC_ASSERT_NEXT(a_batch_clears, en2 && v_s1 && last_s1, cnt_q == '0, "count not cleared after batch end")
	`TFPC_ASSERT_NOW(a_stall_source, !pts.ready, res.valid && !res.ready, "input stalled without a stalled result")

endmodule

// ===== src/tfpc_fence.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle fence closure and orientation
// Combinational logic that derives closure and segment flips from the fences.
// ----------------------------------------------------------------------------
module tfpc_fence import tfpc_pkg::*; (
	input  seg_t        fence [3],
	output fence_stat_t stat
);

	localparam logic [2:0] FLIP_NONE     = 3'b000;
	localparam logic [2:0] FLIP_TWO      = 3'b001;
	localparam logic [2:0] FLIP_ONE_TWO  = 3'b011;
	localparam logic [2:0] FLIP_ONE      = 3'b010;
	localparam logic [2:0] FLIP_ZERO     = 3'b100;

	sgn_t        sg [3][4];
	logic [2:0]  cross_ok;
	logic [2:0]  touch_ok;
	logic [2:0]  flip_d;

	function automatic logic x_within(seg_t s, coord_t cx);
		return (cx >= s.ax && cx <= s.bx) || (cx >= s.bx && cx <= s.ax);
	endfunction

	function automatic logic left_of(logic flipped, sgn_t s);
		return flipped ? (!s.neg && !s.zero) : s.neg;
	endfunction

	function automatic logic same_turn(sgn_t c0a, sgn_t c0b, sgn_t c1a, sgn_t c1b,
		sgn_t c2a, sgn_t c2b, logic [2:0] m);
		logic l0;
		logic l1;
		logic l2;
		l0 = left_of(m[2], m[1] ? c0a : c0b);
		l1 = left_of(m[1], m[0] ? c1a : c1b);
		l2 = left_of(m[0], m[2] ? c2a : c2b);
		return (l0 && l1 && l2) || (!l0 && !l1 && !l2);
	endfunction

	for (genvar gi = 0; gi < 3; gi++) begin : g_pair
		localparam int Nx = (gi + 1) % 3;

		assign sg[gi][0] = cross_sign(cross_prods(fence[gi], fence[Nx].ax, fence[Nx].ay));
		assign sg[gi][1] = cross_sign(cross_prods(fence[gi], fence[Nx].bx, fence[Nx].by));
		assign sg[gi][2] = cross_sign(cross_prods(fence[Nx], fence[gi].ax, fence[gi].ay));
		assign sg[gi][3] = cross_sign(cross_prods(fence[Nx], fence[gi].bx, fence[gi].by));

		assign cross_ok[gi] = (sg[gi][0].neg != sg[gi][1].neg) &&
			(sg[gi][2].neg != sg[gi][3].neg);
		assign touch_ok[gi] = (sg[gi][1].zero && x_within(fence[gi], fence[Nx].bx)) ||
			(sg[gi][0].zero && x_within(fence[gi], fence[Nx].ax)) ||
			(sg[gi][3].zero && x_within(fence[Nx], fence[gi].bx)) ||
			(sg[gi][2].zero && x_within(fence[Nx], fence[gi].ax));
	end

	always_comb begin
		if (same_turn(sg[0][0], sg[0][1], sg[1][0], sg[1][1], sg[2][0], sg[2][1],
			FLIP_NONE)) begin
			flip_d = FLIP_NONE;
		end else if (same_turn(sg[0][0], sg[0][1], sg[1][0], sg[1][1], sg[2][0],
			sg[2][1], FLIP_TWO)) begin
			flip_d = FLIP_TWO;
		end else if (same_turn(sg[0][0], sg[0][1], sg[1][0], sg[1][1], sg[2][0],
			sg[2][1], FLIP_ONE_TWO)) begin
			flip_d = FLIP_ONE_TWO;
		end else if (same_turn(sg[0][0], sg[0][1], sg[1][0], sg[1][1], sg[2][0],
			sg[2][1], FLIP_ONE)) begin
			flip_d = FLIP_ONE;
		end else begin
			flip_d = FLIP_ZERO;
		end
	end

	assign stat = '{closed: &(cross_ok | touch_ok), flip: flip_d};

endmodule
